// ----- sv/tbq_pkg.sv -----
package tbq_pkg;

	localparam int DEF_TIMER_COUNT = 8;
	localparam int DEF_QUEUE_DEPTH = 8;

	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_STOP  = 3'd2;
	localparam logic [2:0] KIND_FETCH = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	localparam logic [1:0] MODE_ONESHOT  = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;

	localparam logic [1:0] TOP_NONE  = 2'd0;
	localparam logic [1:0] TOP_START = 2'd1;
	localparam logic [1:0] TOP_STOP  = 2'd2;
	localparam logic [1:0] TOP_STEP  = 2'd3;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear_drop;
	} q_ctrl_t;

endpackage

// ----- sv/tbq_timer_unit.sv -----
module tbq_timer_unit #(
	parameter int TIMER_COUNT = tbq_pkg::DEF_TIMER_COUNT,
	localparam int ID_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             op,
	input  logic [ID_W-1:0]        idx,
	input  logic [15:0]            period,
	input  logic                   periodic,
	output logic                   expire,
	output logic [TIMER_COUNT-1:0] run
);

	logic [15:0]            remaining_q [TIMER_COUNT];
	logic [15:0]            reload_q [TIMER_COUNT];
	logic [TIMER_COUNT-1:0] run_q;
	logic [TIMER_COUNT-1:0] periodic_q;
	logic [15:0]            cur;
	logic [15:0]            dec;

	// One decrement and zero compare serves every timer in turn.
	always_comb begin
		cur = remaining_q[idx];
		dec = cur - {15'd0, (cur != 16'd0)};
		expire = (op == tbq_pkg::TOP_STEP) && run_q[idx] && (dec == 16'd0);
	end

	assign run = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			periodic_q <= '0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				remaining_q[i] <= 16'd0;
				reload_q[i] <= 16'd0;
			end
		end else begin
			case (op)
				tbq_pkg::TOP_START: begin
					reload_q[idx] <= period;
					remaining_q[idx] <= period;
					periodic_q[idx] <= periodic;
					run_q[idx] <= 1'b1;
				end
				tbq_pkg::TOP_STOP: begin
					run_q[idx] <= 1'b0;
					remaining_q[idx] <= 16'd0;
				end
				tbq_pkg::TOP_STEP: begin
					if (run_q[idx]) begin
						if (dec == 16'd0) begin
							if (periodic_q[idx]) begin
								remaining_q[idx] <= reload_q[idx];
							end else begin
								remaining_q[idx] <= 16'd0;
								run_q[idx] <= 1'b0;
							end
						end else begin
							remaining_q[idx] <= dec;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- sv/tbq_queue.sv -----
module tbq_queue #(
	parameter int TIMER_COUNT = tbq_pkg::DEF_TIMER_COUNT,
	parameter int QUEUE_DEPTH = tbq_pkg::DEF_QUEUE_DEPTH,
	localparam int ID_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1,
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbq_pkg::q_ctrl_t ctrl,
	input  logic [ID_W-1:0]  push_id,
	output logic [ID_W-1:0]  rd_id,
	output logic [CNT_W-1:0] count,
	output logic             full,
	output logic [15:0]      drop
);

	logic [ID_W-1:0]  mem [QUEUE_DEPTH];
	logic [ID_W-1:0]  rd_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      drop_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign count = count_q;
	assign drop = drop_q;
	assign rd_id = rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && !full) begin
			mem[head_q] <= push_id;
		end
		if (ctrl.pop) begin
			rd_q <= mem[tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			drop_q <= 16'd0;
		end else begin
			if (ctrl.push) begin
				if (full) begin
					drop_q <= drop_q + 16'd1;
				end else begin
					head_q <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
					count_q <= count_q + CNT_W'(1);
				end
			end else if (ctrl.pop) begin
				tail_q <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
				count_q <= count_q - CNT_W'(1);
			end
			if (ctrl.clear_drop) begin
				drop_q <= 16'd0;
			end
		end
	end

endmodule

// ----- sv/timer_bank_with_expiry_queue.sv -----
// Timer bank with an expiry queue.
// The input channel (in_valid, in_stall) carries one request: kind, timer_id,
// reload_ticks and mode. The output channel (out_valid, out_stall) returns one
// result per request: accepted, expired_id, running_mask, drop_total and
// queue_fill, all taken after the request has been applied.
// A tick walks the timers one per cycle through a single shared decrement and
// zero-compare unit in ST_TICK, then its result is loaded from ST_RESP into the
// output register. Start, stop, fetch, clear and unused kinds go straight from
// acceptance to ST_RESP; a fetch reads the queue memory through its registered
// read port on acceptance, before the result is loaded.
// A new request is accepted in the cycle after the previous result has been
// loaded into the output register, so the block takes no new request while a
// tick walk runs or a result waits to be loaded.
// If the receiver stalls, the result waits in the output register and the next
// request may still be accepted; its result is held back until the register
// frees up, and no further request is taken meanwhile.
// Reset clears all timers, the queue pointers, the fill and the drop count;
// the queue contents are not cleared and are never read before being written.
module timer_bank_with_expiry_queue #(
	parameter int TIMER_COUNT = tbq_pkg::DEF_TIMER_COUNT,
	parameter int QUEUE_DEPTH = tbq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  timer_id,
	input  logic [15:0] reload_ticks,
	input  logic [1:0]  mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [2:0]  expired_id,
	output logic [7:0]  running_mask,
	output logic [15:0] drop_total,
	output logic [3:0]  queue_fill
);

	localparam int ID_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]             state_q;
	logic [ID_W-1:0]        idx_q;
	logic                   acc_q;
	logic                   fetched_q;
	logic                   take;
	logic                   id_ok;
	logic                   start_ok;
	logic                   load;
	logic [1:0]             t_op;
	logic [ID_W-1:0]        t_idx;
	logic                   expire;
	logic [TIMER_COUNT-1:0] run;
	tbq_pkg::q_ctrl_t       q_ctrl;
	logic [ID_W-1:0]        rd_id;
	logic [CNT_W-1:0]       count;
	logic                   full;
	logic [15:0]            drop;
	logic [31:0]            run_wide;
	logic [31:0]            id_wide;
	logic [31:0]            cnt_wide;
	logic                   out_valid_q;

	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && !in_stall;
	assign id_ok = (timer_id < 8'(TIMER_COUNT));
	assign start_ok = id_ok && (reload_ticks != 16'd0)
		&& ((mode == tbq_pkg::MODE_ONESHOT) || (mode == tbq_pkg::MODE_PERIODIC));
	assign load = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	always_comb begin
		t_op = tbq_pkg::TOP_NONE;
		t_idx = timer_id[ID_W-1:0];
		q_ctrl = '0;
		if (state_q == ST_TICK) begin
			t_op = tbq_pkg::TOP_STEP;
			t_idx = idx_q;
			q_ctrl.push = expire;
		end else if (take) begin
			case (kind)
				tbq_pkg::KIND_START: t_op = start_ok ? tbq_pkg::TOP_START : tbq_pkg::TOP_NONE;
				tbq_pkg::KIND_STOP:  t_op = id_ok ? tbq_pkg::TOP_STOP : tbq_pkg::TOP_NONE;
				tbq_pkg::KIND_FETCH: q_ctrl.pop = (count != '0);
				tbq_pkg::KIND_CLEAR: q_ctrl.clear_drop = 1'b1;
				default: begin
				end
			endcase
		end
	end

	tbq_timer_unit #(
		.TIMER_COUNT(TIMER_COUNT)
	) u_timers (
		.clk(clk),
		.arst_n(arst_n),
		.op(t_op),
		.idx(t_idx),
		.period(reload_ticks),
		.periodic(mode[0]),
		.expire(expire),
		.run(run)
	);

	tbq_queue #(
		.TIMER_COUNT(TIMER_COUNT),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(q_ctrl),
		.push_id(idx_q),
		.rd_id(rd_id),
		.count(count),
		.full(full),
		.drop(drop)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			acc_q <= 1'b0;
			fetched_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						idx_q <= '0;
						fetched_q <= 1'b0;
						case (kind)
							tbq_pkg::KIND_TICK: begin
								acc_q <= 1'b1;
								state_q <= ST_TICK;
							end
							tbq_pkg::KIND_START: begin
								acc_q <= start_ok;
								state_q <= ST_RESP;
							end
							tbq_pkg::KIND_STOP, tbq_pkg::KIND_CLEAR: begin
								acc_q <= 1'b1;
								state_q <= ST_RESP;
							end
							tbq_pkg::KIND_FETCH: begin
								acc_q <= (count != '0);
								fetched_q <= (count != '0);
								state_q <= ST_RESP;
							end
							default: begin
								acc_q <= 1'b0;
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_TICK: begin
					if (idx_q == ID_W'(TIMER_COUNT - 1)) begin
						state_q <= ST_RESP;
					end else begin
						idx_q <= idx_q + ID_W'(1);
					end
				end
				ST_RESP: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign run_wide = 32'(run);
	assign id_wide = 32'(rd_id);
	assign cnt_wide = 32'(count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			accepted <= acc_q;
			expired_id <= fetched_q ? id_wide[2:0] : 3'd0;
			running_mask <= run_wide[7:0];
			drop_total <= drop;
			queue_fill <= cnt_wide[3:0];
		end
	end

	assign out_valid = out_valid_q;

	a_tick_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		take && (kind == tbq_pkg::KIND_TICK) |=> (state_q == ST_TICK) && (idx_q == '0))
		else $error("tick did not start the timer walk at timer zero");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill exceeds its depth");

	a_pop_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctrl.pop |=> (count == $past(count) - CNT_W'(1)))
		else $error("fetch did not reduce the queue fill");

	a_drop_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(drop) |-> $past((q_ctrl.push && full) || q_ctrl.clear_drop))
		else $error("drop count changed without a lost expiry or a clear");

endmodule
